@@ hw/rtl/cdd_pkg.sv @@
// Shared types, codes and calendar helpers for the calendar date decrementer.
package cdd_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned CountW = 10;
  // Enough for the largest week count expanded to days (1023 * 7).
  localparam int unsigned StepW  = 13;

  // Multiplicative inverse of 25 modulo 2^16 and the divisibility bound.
  localparam logic [YearW-1:0] Inv25   = 16'h5C29;
  localparam logic [YearW-1:0] Div25Lim = 16'(65535 / 25);

  typedef enum logic [2:0] {
    ACT_DAYS       = 3'd0,
    ACT_WEEKS      = 3'd1,
    ACT_MONTHS     = 3'd2,
    ACT_YEARS      = 3'd3,
    ACT_DECADES    = 3'd4,
    ACT_CENTURY    = 3'd5,
    ACT_MILLENNIUM = 3'd6
  } action_t;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  typedef struct packed {
    logic load;   // capture a new transaction
    logic step;   // take one day or one month away
    logic store;  // move the working date into the result register
  } cdd_cmd_t;

  typedef struct packed {
    logic cnt_zero;  // no steps left
  } cdd_sts_t;

  // Days in a month; February depends on the leap flag.
  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      default:                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

@@ hw/rtl/cdd_ctrl.sv @@
// Controller state machine for the calendar date decrementer.
module cdd_ctrl
  import cdd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cdd_sts_t sts,
  output cdd_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREP;
        end
      end
      // Wait state in which the registered leap flag takes up the freshly loaded year.
      ST_PREP: state_next = ST_RUN;
      ST_RUN: begin
        if (sts.cnt_zero) begin
          state_next = ST_FIN;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.store  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.store) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/cdd_dp.sv @@
// Datapath of the calendar date decrementer: working date, step counter and result register.
module cdd_dp
  import cdd_pkg::*;
(
  input  logic                     clk,
  input  cdd_cmd_t                 cmd,
  output cdd_sts_t                 sts,
  input  logic [2:0]               action,
  input  logic [CountW-1:0]        step_count,
  input  logic [DayW-1:0]          day_in,
  input  logic [MonthW-1:0]        month_in,
  input  logic signed [YearW-1:0]  year_in,
  output logic [DayW-1:0]          day_out,
  output logic [MonthW-1:0]        month_out,
  output logic signed [YearW-1:0]  year_out
);

  logic [DayW-1:0]         day;
  logic [MonthW-1:0]       month;
  logic signed [YearW-1:0] year;
  logic [StepW-1:0]        cnt;
  logic                    by_month;
  logic                    leap;

  logic [MonthW-1:0]       month_clamp;
  logic [StepW-1:0]        cnt_load;
  logic signed [YearW-1:0] year_load;
  logic [StepW:0]          decade_years;

  logic [YearW-1:0]        year_abs;
  logic [YearW-1:0]        year_prod;
  logic                    div4, div16, div25;

  logic [DayW-1:0]         day_next;
  logic [MonthW-1:0]       month_next;
  logic signed [YearW-1:0] year_next;

  assign sts.cnt_zero = (cnt == '0);

  // Load values for a new transaction.
  always_comb begin
    month_clamp = month_in;
    if (month_in < MonthJan) month_clamp = MonthJan;
    if (month_in > MonthDec) month_clamp = MonthDec;

    decade_years = {1'b0, step_count, 3'b000} + {3'b000, step_count, 1'b0};
    cnt_load  = '0;
    year_load = year_in;
    case (action)
      ACT_DAYS:    cnt_load = {3'b000, step_count};
      ACT_WEEKS:   cnt_load = {step_count, 3'b000} - {3'b000, step_count};
      ACT_MONTHS:  cnt_load = {3'b000, step_count};
      ACT_YEARS:   year_load = year_in - $signed({6'b0, step_count});
      ACT_DECADES: year_load = year_in - $signed({2'b0, decade_years});
      ACT_CENTURY: begin
        if (year_in > 16'sd100) year_load = year_in - 16'sd100;
      end
      ACT_MILLENNIUM: begin
        if (year_in > 16'sd1000) year_load = year_in - 16'sd1000;
      end
      default: ;
    endcase
  end

  // Leap test: divisible by 25 via the modular inverse on the magnitude.
  always_comb begin
    year_abs  = year[YearW-1] ? YearW'(-year) : year;
    year_prod = YearW'(year_abs * Inv25);
    div25     = (year_prod <= Div25Lim);
    div4      = (year[1:0] == 2'b00);
    div16     = (year[3:0] == 4'b0000);
  end

  // One step backwards by a day or by a month.
  always_comb begin
    day_next   = day;
    month_next = month;
    year_next  = year;
    if (by_month) begin
      if (month == MonthJan) begin
        year_next  = year - 16'sd1;
        month_next = MonthDec;
      end else begin
        month_next = month - 4'd1;
      end
    end else if (day == 5'd1) begin
      if (month == MonthJan) begin
        year_next  = year - 16'sd1;
        month_next = MonthDec;
        day_next   = 5'd31;
      end else begin
        month_next = month - 4'd1;
        day_next   = month_length(month - 4'd1, leap);
      end
    end else begin
      day_next = day - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    leap <= (div4 && !div25) || (div16 && div25);
    if (cmd.load) begin
      day      <= day_in;
      month    <= month_clamp;
      year     <= year_load;
      cnt      <= cnt_load;
      by_month <= (action == ACT_MONTHS);
    end else if (cmd.step) begin
      day   <= day_next;
      month <= month_next;
      year  <= year_next;
      cnt   <= cnt - StepW'(1);
    end
    if (cmd.store) begin
      day_out   <= day;
      month_out <= month;
      year_out  <= year;
    end
  end

endmodule

@@ hw/rtl/calendar_date_decrementer.sv @@
// Top level of the calendar date decrementer: controller and datapath joined.
//
//   Channel  Direction  Handshake              Payload
//   input    in         in_valid / in_ready    action, step_count, day_in, month_in, year_in
//   result   out        out_valid / out_ready  day_out, month_out, year_out
//
// A transaction runs from acceptance through the load, a preparation state,
// N single steps and the store into the output register, where N is the
// count for days and months, seven times the count for weeks, and zero for
// the year actions. The working date moves back by one day or one month per
// cycle in the datapath's step logic, so N is at most 7161.
// Reset is synchronous and active high; it returns the controller to idle
// and drops out_valid. The next input transaction may be accepted while a
// result still waits in the output register; a finished date only waits for
// that register when an earlier result has not yet been taken.
module calendar_date_decrementer
  import cdd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              action,
  input  logic [CountW-1:0]       step_count,
  input  logic [DayW-1:0]         day_in,
  input  logic [MonthW-1:0]       month_in,
  input  logic signed [YearW-1:0] year_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DayW-1:0]         day_out,
  output logic [MonthW-1:0]       month_out,
  output logic signed [YearW-1:0] year_out
);

  // Commands flow from the controller to the datapath, status back.
  cdd_cmd_t cmd;
  cdd_sts_t sts;

  // The controller sequences load, stepping and the hand-over to the
  // output register, and owns both handshake flags.
  cdd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the working date, the step counter, the registered
  // leap flag and the result register.
  cdd_dp u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .action     (action),
    .step_count (step_count),
    .day_in     (day_in),
    .month_in   (month_in),
    .year_in    (year_in),
    .day_out    (day_out),
    .month_out  (month_out),
    .year_out   (year_out)
  );

endmodule

@@ hw/rtl/cdd_check.sv @@
// Port-level checks for the calendar date decrementer, bound to the top level.
module cdd_check
  import cdd_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [2:0]              action,
  input logic [CountW-1:0]       step_count,
  input logic [DayW-1:0]         day_in,
  input logic [MonthW-1:0]       month_in,
  input logic signed [YearW-1:0] year_in,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [DayW-1:0]         day_out,
  input logic [MonthW-1:0]       month_out,
  input logic signed [YearW-1:0] year_out
);

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A held result keeps its value until taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_out) &&
                               $stable(month_out) && $stable(year_out))
    else $error("pending result changed");

  // Any result carries a month in range.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (month_out >= 4'd1) && (month_out <= 4'd12))
    else $error("month out of range");

  // Only one transaction is in progress at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind calendar_date_decrementer cdd_check u_cdd_check (.*);
